### rtl/core/paired_slot_iv_counter_store_unit_defines.svh
// assertion macros shared by the paired slot iv counter store rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef PAIRED_SLOT_IV_COUNTER_STORE_UNIT_DEFINES_SVH
`define PAIRED_SLOT_IV_COUNTER_STORE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PSIV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psiv: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PSIV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psiv: next-cycle check failed");

`endif

### rtl/core/psiv_pkg.sv
// shared types, constants and slot kind decode for the iv counter store
// no dependencies
`default_nettype none

package psiv_pkg;

  localparam int unsigned CTR_W       = 64;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IDX_W       = 9;
  localparam int unsigned MIXED_SLOTS = 6;
  localparam int unsigned S_TDATA_W   = 16;
  localparam int unsigned M_TDATA_W   = 136;
  localparam int unsigned RES_W       = 132;

  typedef enum logic [OP_W-1:0] {
    OP_ENC  = 2'd0,
    OP_DEC  = 2'd1,
    OP_BOTH = 2'd2,
    OP_HMAC = 2'd3
  } rot_op_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_CIPHER = 2'd1,
    KIND_HMAC   = 2'd2
  } slot_kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } psiv_cmd_t;

  // kind of a slot from its index: reserved slots and slots past the store have no counter
  function automatic slot_kind_e slot_kind(logic [IDX_W-1:0] idx,
                                           logic [IDX_W-1:0] slot_cnt,
                                           logic [IDX_W-1:0] noctr);
    logic [IDX_W-1:0] rel;
    slot_kind_e       kind;
    rel = idx - noctr;
    if (idx >= slot_cnt || idx < noctr) begin
      kind = KIND_NONE;
    end else if (idx < noctr + IDX_W'(MIXED_SLOTS)) begin
      kind = rel[0] ? KIND_HMAC : KIND_CIPHER;
    end else begin
      kind = KIND_CIPHER;
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

### rtl/core/psiv_ctrl.sv
// controller: request handshake, two-state sequencer and result valid flag
// depends on psiv_pkg and the shared assertion macro header
`default_nettype none
`include "paired_slot_iv_counter_store_unit_defines.svh"

module psiv_ctrl
  import psiv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  wire logic      m_tready_i,
  output psiv_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_vld_q, out_vld_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs: take a request only when the result slot is free or freeing
  always_comb begin
    s_tready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o    = !out_vld_q || m_tready_i;
        cmd_o.capture = s_tvalid_i && s_tready_o;
      end
      ST_EXEC: begin
        cmd_o.commit = 1'b1;
      end
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd_o.commit) begin
      out_vld_d = 1'b1;
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_tvalid_o = out_vld_q;

  // sequencing checks
  `PSIV_ASSERT_NXT(a_capture_then_commit, cmd_o.capture, cmd_o.commit)
  `PSIV_ASSERT_IMP(a_commit_after_capture, cmd_o.commit, $past(cmd_o.capture))
  `PSIV_ASSERT_NXT(a_commit_shows_result, cmd_o.commit, m_tvalid_o)
  `PSIV_ASSERT_IMP(a_busy_blocks_input, state_q == ST_EXEC, !s_tready_o)

endmodule

`default_nettype wire

### rtl/core/psiv_dp.sv
// datapath: paired counter memory, per-row valid flags, check/increment, result register
// depends on psiv_pkg
`default_nettype none

module psiv_dp
  import psiv_pkg::*;
#(
  parameter int unsigned SLOT_COUNT  = 64,
  parameter int unsigned NOCTR_SLOTS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire psiv_cmd_t         cmd_i,
  input  wire logic [SLOT_W-1:0] slot_index_i,
  input  wire logic [OP_W-1:0]   rotate_op_i,
  input  wire logic              advance_i,
  output logic [RES_W-1:0]       result_o
);

  // an odd slot count still needs a row for its last, unpaired slot
  localparam int unsigned ROWS  = (SLOT_COUNT + 1) / 2;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // one row holds a pair: even counter low, odd counter high
  logic [2*CTR_W-1:0] mem_q [ROWS];
  logic [ROWS-1:0]    row_vld_q;

  logic [2*CTR_W-1:0] rd_row_q;
  logic               rd_vld_q;
  logic [ROW_W-1:0]   req_row_q;
  rot_op_e            req_op_q;
  logic               req_adv_q;
  slot_kind_e         kind_even_q, kind_odd_q;
  logic [RES_W-1:0]   res_q;

  logic [IDX_W-1:0]   base_idx, odd_idx, row_ext;
  logic [ROW_W-1:0]   rd_addr;
  logic               enc_side, dec_side;
  logic               enc_has, dec_has;
  logic [CTR_W-1:0]   enc_cur, dec_cur, enc_new, dec_new;
  logic               refused, wr_en;
  logic [RES_W-1:0]   res_d;

  // request decode at capture
  assign base_idx = {{(IDX_W-SLOT_W){1'b0}}, slot_index_i[SLOT_W-1:1], 1'b0};
  assign odd_idx  = {{(IDX_W-SLOT_W){1'b0}}, slot_index_i[SLOT_W-1:1], 1'b1};
  assign row_ext  = {{(IDX_W-SLOT_W+1){1'b0}}, slot_index_i[SLOT_W-1:1]};
  assign rd_addr  = row_ext[ROW_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_row_q   <= rd_addr;
      req_op_q    <= rot_op_e'(rotate_op_i);
      req_adv_q   <= advance_i;
      kind_even_q <= slot_kind(base_idx, IDX_W'(SLOT_COUNT), IDX_W'(NOCTR_SLOTS));
      kind_odd_q  <= slot_kind(odd_idx, IDX_W'(SLOT_COUNT), IDX_W'(NOCTR_SLOTS));
    end
  end

  // counter memory: one read at capture, one write-back at commit
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[req_row_q] <= {dec_new, enc_new};
    if (cmd_i.capture) rd_row_q <= mem_q[rd_addr];
  end

  // row valid flags stand in for clearing the memory at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) row_vld_q[req_row_q] <= 1'b1;
      if (cmd_i.capture) rd_vld_q <= row_vld_q[rd_addr];
    end
  end

  // check for exhaustion and increment
  assign enc_side = (req_op_q == OP_ENC) || (req_op_q == OP_BOTH);
  assign dec_side = (req_op_q != OP_ENC);
  assign enc_has  = (kind_even_q != KIND_NONE);
  assign dec_has  = (kind_odd_q != KIND_NONE);
  assign enc_cur  = (enc_has && rd_vld_q) ? rd_row_q[CTR_W-1:0] : '0;
  assign dec_cur  = (dec_has && rd_vld_q) ? rd_row_q[2*CTR_W-1:CTR_W] : '0;

  assign refused = req_adv_q && ((enc_side && (&enc_cur)) || (dec_side && (&dec_cur)));

  assign enc_new = (req_adv_q && enc_side && enc_has) ? enc_cur + CTR_W'(1) : enc_cur;
  assign dec_new = (req_adv_q && dec_side && dec_has) ? dec_cur + CTR_W'(1) : dec_cur;

  // write back only rows that hold a counter, so aliased rows stay untouched
  assign wr_en = cmd_i.commit && req_adv_q && !refused
               && ((enc_side && enc_has) || (dec_side && dec_has));

  // result, lowest bit first: status, enc valid, enc counter, dec valid,
  // dec counter, work launch
  always_comb begin
    if (refused) begin
      res_d    = '0;
      res_d[0] = 1'b1;
    end else begin
      res_d = {dec_side && (kind_odd_q == KIND_HMAC),
               dec_side ? dec_new : {CTR_W{1'b0}},
               dec_side,
               enc_side ? enc_new : {CTR_W{1'b0}},
               enc_side,
               1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) res_q <= res_d;
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

### rtl/core/paired_slot_iv_counter_store_unit.sv
// a request is captured on transfer, committed in ST_EXEC, then offered as a result
// input: requests are taken in ST_IDLE only, and not while a result waits unaccepted;
// the counter memory is read in the transfer cycle and written back in the next
// reset: controller idle, no result pending; all counters read zero through per-row
// valid flags cleared by reset, so there is no clearing pass
`default_nettype none

module paired_slot_iv_counter_store_unit
  import psiv_pkg::*;
#(
  parameter int unsigned SLOT_COUNT  = 64,
  parameter int unsigned NOCTR_SLOTS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // slot_index [5:0], rotate_op [7:6], advance [8], zero [15:9]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // status [0], enc_valid [1], enc_counter [65:2], dec_valid [66],
  // dec_counter [130:67], work_launch [131], zero [135:132]
  output logic [M_TDATA_W-1:0]      m_axis_tdata
);

  psiv_cmd_t        cmd;
  logic [RES_W-1:0] result;

  // sequencer
  psiv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  // counter store and arithmetic
  psiv_dp #(
    .SLOT_COUNT  (SLOT_COUNT),
    .NOCTR_SLOTS (NOCTR_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .slot_index_i (s_axis_tdata[5:0]),
    .rotate_op_i  (s_axis_tdata[7:6]),
    .advance_i    (s_axis_tdata[8]),
    .result_o     (result)
  );

  assign m_axis_tdata = {{(M_TDATA_W-RES_W){1'b0}}, result};

endmodule

`default_nettype wire
